### rtl/core/sot_pkg.sv
// sot_pkg: types and constants for the subnet overlap table.
// Used by the channel interfaces and by subnet_overlap_table. No dependencies.
package sot_pkg;

  localparam int unsigned IF_INDEX_W = 32;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PREFIX_W   = 6;
  localparam logic [PREFIX_W-1:0] PREFIX_MAX = 6'd32;

  typedef enum logic {
    MODE_ADD    = 1'b0,
    MODE_DELETE = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_OVERLAP = 3'd1,
    ST_DELETED = 3'd2,
    ST_MISSING = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef struct packed {
    logic [IF_INDEX_W-1:0] if_index;
    logic [ADDR_W-1:0]     address;
    logic [PREFIX_W-1:0]   prefix;
  } entry_t;

endpackage

### rtl/core/sot_if.sv
// sot_cmd_if / sot_rsp_if: valid/ready channels of the subnet overlap table.
// Depends on sot_pkg.
interface sot_cmd_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [sot_pkg::IF_INDEX_W-1:0]    if_index;
  logic [sot_pkg::ADDR_W-1:0]        ip_addr;
  logic [sot_pkg::PREFIX_W-1:0]      mask_len;

  modport source (output valid, mode, if_index, ip_addr, mask_len, input ready);
  modport sink   (input valid, mode, if_index, ip_addr, mask_len, output ready);
endinterface

interface sot_rsp_if;
  logic                              valid;
  logic                              ready;
  sot_pkg::status_t                  status;
  logic [sot_pkg::IF_INDEX_W-1:0]    conflict_index;

  modport source (output valid, status, conflict_index, input ready);
  modport sink   (input valid, status, conflict_index, output ready);
endinterface

### rtl/core/subnet_overlap_table.sv
// subnet_overlap_table: interface address table with IPv4 subnet overlap check.
// Depends on sot_pkg, sot_cmd_if and sot_rsp_if.
//
//   channel  dir  payload                                  protocol
//   cmd      in   mode, if_index, ip_addr, mask_len        valid/ready
//   rsp      out  status, conflict_index                   valid/ready
//
// Each item is accepted in S_IDLE, then walks the entry memory in S_WALK (one read
// per cycle through the registered read port, then the pipeline drains), then
// updates the table and loads the result register in S_FINISH.
// cmd.ready is high only while idle. The result register holds until taken; a
// finishing item waits for it. Reset is synchronous; it clears the state and valid bits, not the entries.
module subnet_overlap_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input logic      clk,
  input logic      rst,
  sot_cmd_if.sink  cmd,
  sot_rsp_if.source rsp
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state;

  sot_pkg::entry_t mem [TABLE_ENTRIES];
  sot_pkg::entry_t rd_data;
  logic            mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic            mem_re;

  logic [TABLE_ENTRIES-1:0] slot_valid;

  logic                                mode;
  logic [sot_pkg::IF_INDEX_W-1:0]      key;
  logic [sot_pkg::ADDR_W-1:0]          addr;
  logic [sot_pkg::PREFIX_W-1:0]        plen;

  logic [CNT_W-1:0] rd_cnt;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;

  logic             match_found;
  logic [IDX_W-1:0] match_slot;
  logic             free_found;
  logic [IDX_W-1:0] free_slot;
  logic             ovl_found;
  logic [sot_pkg::IF_INDEX_W-1:0] ovl_key;

  logic                         cmp_live;
  logic                         cmp_hit;
  logic                         cmp_ovl;
  logic [sot_pkg::PREFIX_W-1:0] min_len;
  logic [sot_pkg::ADDR_W-1:0]   mask;
  logic                         rd_more;
  logic                         can_load;
  logic                         rsp_load;
  logic                         add_ok;
  logic [IDX_W-1:0]             add_slot;
  logic [sot_pkg::PREFIX_W-1:0] plen_in;

  assign cmd.ready = (state == S_IDLE);
  assign plen_in   = (cmd.mask_len > sot_pkg::PREFIX_MAX) ? sot_pkg::PREFIX_MAX
                                                          : cmd.mask_len;

  assign rd_more  = (rd_cnt < CNT_W'(TABLE_ENTRIES));
  assign mem_re   = (state == S_WALK) && rd_more;
  assign can_load = !rsp.valid || rsp.ready;
  assign rsp_load = (state == S_FINISH) && can_load;

  // compare stage on the entry just read
  always_comb begin
    cmp_live = cmp_vld && slot_valid[cmp_idx];
    cmp_hit  = cmp_live && (rd_data.if_index == key);
    min_len  = (rd_data.prefix < plen) ? rd_data.prefix : plen;
    if (min_len == '0) begin
      mask = '0;
    end else begin
      mask = {sot_pkg::ADDR_W{1'b1}} << (sot_pkg::PREFIX_MAX - min_len);
    end
    cmp_ovl = cmp_live && !cmp_hit && ((rd_data.address & mask) == (addr & mask));
  end

  assign add_ok   = match_found || free_found;
  assign add_slot = match_found ? match_slot : free_slot;
  assign mem_we   = rsp_load && (mode == sot_pkg::MODE_ADD) && add_ok;
  assign mem_waddr = add_slot;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= '{if_index: key, address: addr, prefix: plen};
    end
    if (mem_re) begin
      rd_data <= mem[rd_cnt[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      rsp.valid  <= 1'b0;
      cmp_vld    <= 1'b0;
      rd_cnt     <= '0;
    end else begin
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            mode        <= cmd.mode;
            key         <= cmd.if_index;
            addr        <= cmd.ip_addr;
            plen        <= plen_in;
            rd_cnt      <= '0;
            cmp_vld     <= 1'b0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
            ovl_found   <= 1'b0;
            state       <= S_WALK;
          end
        end
        S_WALK: begin
          cmp_vld <= rd_more;
          cmp_idx <= rd_cnt[IDX_W-1:0];
          if (rd_more) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
          end
          if (cmp_vld) begin
            if (cmp_hit) begin
              match_found <= 1'b1;
              match_slot  <= cmp_idx;
            end
            if (!slot_valid[cmp_idx] && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= cmp_idx;
            end
            if (cmp_ovl && !ovl_found) begin
              ovl_found <= 1'b1;
              ovl_key   <= rd_data.if_index;
            end
          end
          if (!rd_more && !cmp_vld) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (can_load) begin
            if (mode == sot_pkg::MODE_DELETE) begin
              rsp.conflict_index <= '0;
              if (match_found) begin
                slot_valid[match_slot] <= 1'b0;
                rsp.status             <= sot_pkg::ST_DELETED;
              end else begin
                rsp.status <= sot_pkg::ST_MISSING;
              end
            end else if (!add_ok) begin
              rsp.conflict_index <= '0;
              rsp.status         <= sot_pkg::ST_FULL;
            end else begin
              slot_valid[add_slot] <= 1'b1;
              if (ovl_found) begin
                rsp.status         <= sot_pkg::ST_OVERLAP;
                rsp.conflict_index <= ovl_key;
              end else begin
                rsp.status         <= sot_pkg::ST_ADDED;
                rsp.conflict_index <= '0;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sim/sot_overlap_checker.sv
// sot_overlap_checker: watches the cmd and rsp channels of subnet_overlap_table,
// keeps its own copy of the address table and compares every response item.
// Depends on sot_pkg, sot_cmd_if and sot_rsp_if.
module sot_overlap_checker #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic clk,
  input  logic rst,
  sot_cmd_if   cmd,
  sot_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sot_pkg::status_t                  status;
    logic [sot_pkg::IF_INDEX_W-1:0]    conflict;
  } outcome_t;

  outcome_t         awaited_outcomes[$];
  outcome_t         want;
  logic             slot_used [TABLE_ENTRIES];
  sot_pkg::entry_t  slot_data [TABLE_ENTRIES];

  function automatic logic [sot_pkg::ADDR_W-1:0] subnet_mask(
      input logic [sot_pkg::PREFIX_W-1:0] plen);
    if (plen == '0) return '0;
    return 32'hFFFF_FFFF << (32 - int'(plen));
  endfunction

  // Applies one request to the shadow table and returns the response it causes.
  function automatic outcome_t apply_request(input sot_pkg::mode_t m,
                                             input logic [sot_pkg::IF_INDEX_W-1:0] key,
                                             input logic [sot_pkg::ADDR_W-1:0] addr,
                                             input logic [sot_pkg::PREFIX_W-1:0] raw_plen);
    logic [sot_pkg::PREFIX_W-1:0] plen;
    logic [sot_pkg::PREFIX_W-1:0] shorter;
    logic [sot_pkg::ADDR_W-1:0]   mask;
    outcome_t                     res;
    int                           slot;
    bit                           found;
    plen = (raw_plen > sot_pkg::PREFIX_MAX) ? sot_pkg::PREFIX_MAX : raw_plen;
    res.conflict = '0;
    slot = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot < 0 && slot_used[i] && slot_data[i].if_index == key) slot = i;
    if (m == sot_pkg::MODE_DELETE) begin
      if (slot >= 0) begin
        slot_used[slot] = 1'b0;
        res.status = sot_pkg::ST_DELETED;
      end else begin
        res.status = sot_pkg::ST_MISSING;
      end
    end else begin
      if (slot < 0)
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (slot < 0 && !slot_used[i]) slot = i;
      if (slot < 0) begin
        res.status = sot_pkg::ST_FULL;
      end else begin
        slot_used[slot] = 1'b1;
        slot_data[slot].if_index = key;
        slot_data[slot].address = addr;
        slot_data[slot].prefix = plen;
        res.status = sot_pkg::ST_ADDED;
        found = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!found && i != slot && slot_used[i]) begin
            shorter = (slot_data[i].prefix < plen) ? slot_data[i].prefix : plen;
            mask = subnet_mask(shorter);
            if ((slot_data[i].address & mask) == (addr & mask)) begin
              found = 1'b1;
              res.status = sot_pkg::ST_OVERLAP;
              res.conflict = slot_data[i].if_index;
            end
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_used[i] = 1'b0;
      awaited_outcomes.delete();
      mismatches = 0;
      outstanding = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t mismatch: unexpected item status=%0d conflict=%0h",
                     $realtime, rsp.status, rsp.conflict_index);
        end else begin
          want = awaited_outcomes.pop_front();
          if (rsp.status !== want.status || rsp.conflict_index !== want.conflict) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t mismatch: status exp=%0d got=%0d conflict exp=%0h got=%0h",
                       $realtime, want.status, rsp.status, want.conflict,
                       rsp.conflict_index);
          end
        end
      end
      if (cmd.valid && cmd.ready)
        awaited_outcomes.push_back(apply_request(sot_pkg::mode_t'(cmd.mode),
                                                 cmd.if_index, cmd.ip_addr,
                                                 cmd.mask_len));
      outstanding = awaited_outcomes.size();
    end
  end

endmodule

### sim/subnet_overlap_table_tb.sv
// subnet_overlap_table_tb: drives add/delete items into subnet_overlap_table with
// random gaps and stalls and gives the verdict from sot_overlap_checker.
// Depends on sot_pkg, sot_cmd_if, sot_rsp_if, sot_overlap_checker and the block.
module subnet_overlap_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned PLEN_W        = sot_pkg::PREFIX_W;
  localparam int          CYCLE_LIMIT   = 400_000;
  localparam int          HOLD_CYCLES   = 250;

  logic clk;
  logic rst = 1'b1;
  int   mismatches;
  int   outstanding;
  int   cycle_count = 0;
  bit   steady_flow = 1'b0;
  int   hold_req = 0;

  sot_cmd_if cmd_ch();
  sot_rsp_if rsp_ch();

  subnet_overlap_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  sot_overlap_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) checker_i (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_op(input sot_pkg::mode_t m,
                         input logic [sot_pkg::IF_INDEX_W-1:0] key,
                         input logic [sot_pkg::ADDR_W-1:0] addr,
                         input logic [sot_pkg::PREFIX_W-1:0] plen);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode <= m;
    cmd_ch.if_index <= key;
    cmd_ch.ip_addr <= addr;
    cmd_ch.mask_len <= plen;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic random_phase(input int count, input int key_span, input int delete_pct,
                              input bit steady, input bit with_hold);
    logic [sot_pkg::IF_INDEX_W-1:0] key_base;
    logic [sot_pkg::ADDR_W-1:0]     nets[4];
    logic [sot_pkg::ADDR_W-1:0]     addr;
    logic [sot_pkg::PREFIX_W-1:0]   plen;
    sot_pkg::mode_t                 m;
    key_base = $urandom;
    nets[0] = $urandom;
    nets[1] = nets[0] ^ 32'h0001_0000;
    nets[2] = nets[0] ^ 32'h0000_0100;
    nets[3] = $urandom;
    steady_flow = steady;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 8) begin
        // noise: anything the fields allow
        m = sot_pkg::mode_t'($urandom_range(0, 1));
        send_op(m, $urandom, $urandom, PLEN_W'($urandom_range(0, 63)));
      end else begin
        m = ($urandom_range(0, 99) < delete_pct) ? sot_pkg::MODE_DELETE
                                                 : sot_pkg::MODE_ADD;
        addr = nets[2'($urandom_range(0, 3))] ^ ($urandom >> $urandom_range(8, 31));
        plen = PLEN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(8, 32));
        if (with_hold && n == count / 2) hold_req++;
        send_op(m, key_base + $urandom_range(0, key_span - 1), addr, plen);
      end
    end
    wait_drained();
    steady_flow = 1'b0;
  endtask

  // Response side: random ready gaps, and one long hold-off when asked.
  initial begin
    int gap;
    int hold_done;
    hold_done = 0;
    rsp_ch.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_done != hold_req) begin
        hold_done++;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.mode = sot_pkg::MODE_ADD;
    cmd_ch.if_index = '0;
    cmd_ch.ip_addr = '0;
    cmd_ch.mask_len = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_op(sot_pkg::MODE_DELETE, 32'h0, 32'h0, 6'd0);
    send_op(sot_pkg::MODE_ADD, 32'h0, 32'h0, 6'd0);
    send_op(sot_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd32);
    send_op(sot_pkg::MODE_ADD, 32'h0, 32'h0A00_0000, 6'd8);
    send_op(sot_pkg::MODE_ADD, 32'd5, 32'h0A01_0203, 6'd63);
    send_op(sot_pkg::MODE_ADD, 32'd6, 32'h0A01_0203, 6'd33);
    send_op(sot_pkg::MODE_DELETE, 32'h0, 32'hFFFF_FFFF, 6'd63);
    send_op(sot_pkg::MODE_DELETE, 32'h0, 32'h0, 6'd0);
    for (int i = 0; i < 14; i++)
      send_op(sot_pkg::MODE_ADD, 32'd100 + i, 32'hC0A8_0000 + i, 6'd32);
    send_op(sot_pkg::MODE_ADD, 32'd5, 32'h0A01_0204, 6'd24);
    send_op(sot_pkg::MODE_DELETE, 32'd100, 32'h0, 6'd0);
    send_op(sot_pkg::MODE_ADD, 32'd200, 32'hC0A8_0001, 6'd31);
    wait_drained();

    random_phase(250, 6, 30, 1'b0, 1'b0);
    random_phase(250, 20, 25, 1'b1, 1'b0);
    random_phase(250, 40, 10, 1'b0, 1'b1);
    random_phase(250, 12, 40, 1'b0, 1'b0);
    random_phase(250, 18, 20, 1'b1, 1'b1);
    random_phase(250, 8, 50, 1'b0, 1'b0);

    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/sot_pkg.sv
rtl/core/sot_if.sv
rtl/core/subnet_overlap_table.sv
sim/sot_overlap_checker.sv
sim/subnet_overlap_table_tb.sv
